// ===== rtl/mmrd_pkg.sv =====
// Package for the row distance block: metric codes, sizes and sequencer states.
`timescale 1ns / 1ps
package mmrd_pkg;
   localparam int ROW_BITS = 8;
   localparam int COL_BITS = 6;
   localparam int ADDR_BITS = ROW_BITS + COL_BITS;
   localparam int ENTRY_BITS = 33;
   localparam int DEPTH = 1 << ADDR_BITS;
   localparam logic [6:0] MAX_COLS = 7'd64;

   localparam logic [3:0] MET_EUCLID = 4'd0;
   localparam logic [3:0] MET_SQ_EUCLID = 4'd1;
   localparam logic [3:0] MET_CHORD = 4'd2;
   localparam logic [3:0] MET_SQ_CHORD = 4'd3;
   localparam logic [3:0] MET_BRAY = 4'd4;
   localparam logic [3:0] MET_CHISQ = 4'd5;
   localparam logic [3:0] MET_SQ_CHISQ = 4'd6;
   localparam logic [3:0] MET_MANHATTAN = 4'd7;
   localparam logic [3:0] MET_GOWER = 4'd8;
   localparam logic [3:0] MET_ALT_GOWER = 4'd9;

   localparam logic CSR_METRIC = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_COMPARE = 1'b1;

   // Root steps: a plain integer root, or one with eight extra fraction pairs.
   localparam logic [5:0] SQ_STEPS_INT = 6'd32;
   localparam logic [5:0] SQ_STEPS_FRAC = 6'd40;

   localparam logic [47:0] DIST_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic signed [63:0] CHI_LIM = 64'sh2000_0000_0000_0000;

   typedef enum logic [3:0] {
      S_IDLE, S_RDA, S_RDB, S_COL, S_MUL, S_ACC, S_SQA, S_SQB,
      S_DIV, S_CHI, S_FIN, S_FROOT, S_FDIV
   } state_type;
endpackage

// ===== rtl/mmrd_matrix_ram.sv =====
// Sample matrix memory: one write port and one registered read port.
`timescale 1ns / 1ps
module mmrd_matrix_ram
   import mmrd_pkg::*;
(
   input  logic                  clock,
   input  logic                  write_enable,
   input  logic [ADDR_BITS-1:0]  write_addr,
   input  logic [ENTRY_BITS-1:0] write_data,
   input  logic [ADDR_BITS-1:0]  read_addr,
   output logic [ENTRY_BITS-1:0] read_data
);
   logic [ENTRY_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
      read_data <= mem[read_addr];
   end
endmodule

// ===== rtl/mmrd_sqrt.sv =====
// Iterative floor square root, one radicand bit pair per cycle.
`timescale 1ns / 1ps
module mmrd_sqrt
   import mmrd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   input  logic [5:0]  steps,
   output logic        done,
   output logic [39:0] root
);
   logic [63:0] src_ff, src_in;
   logic [39:0] root_ff, root_in;
   logic [43:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff;
   logic        run_ff, done_ff;
   logic [43:0] rem_sh, trial;
   logic        ge;

   always_comb begin
      rem_sh = {rem_ff[41:0], src_ff[63:62]};
      trial = {2'b00, root_ff, 2'b01};
      ge = rem_sh >= trial;
      rem_in = ge ? rem_sh - trial : rem_sh;
      root_in = {root_ff[38:0], ge};
      src_in = {src_ff[61:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            src_ff <= radicand;
            root_ff <= '0;
            rem_ff <= '0;
            cnt_ff <= steps;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            src_ff <= src_in;
            root_ff <= root_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// ===== rtl/mmrd_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mmrd_div
   import mmrd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [39:0] divisor,
   output logic        done,
   output logic [63:0] quotient,
   output logic [39:0] remainder
);
   logic [63:0] q_ff;
   logic [40:0] r_ff, r_sh, r_in;
   logic [39:0] dvs_ff;
   logic [6:0]  cnt_ff;
   logic        run_ff, done_ff, ge;

   always_comb begin
      r_sh = {r_ff[39:0], q_ff[63]};
      ge = r_sh >= {1'b0, dvs_ff};
      r_in = ge ? r_sh - {1'b0, dvs_ff} : r_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            q_ff <= dividend;
            r_ff <= '0;
            dvs_ff <= divisor;
            cnt_ff <= 7'd64;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            q_ff <= {q_ff[62:0], ge};
            r_ff <= r_in;
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quotient = q_ff;
   assign remainder = r_ff[39:0];
endmodule

// ===== rtl/multi_metric_row_distance.sv =====
// Top level: row-pair dissimilarity engine over a stored sample matrix.
//
// A transaction is taken when start is high and busy is low. A load
// (operation 0) writes one element and its missing mark into the matrix
// memory in that cycle and leaves busy low. A compare (operation 1) raises
// busy and walks the columns in use, reading row A then row B of each
// column through the single read port of the matrix memory, plus a
// multiply and accumulate in the Euclidean, chord and chi-square metrics,
// with two roots before it in the chord metrics and a divide after it in
// the chi-square metrics. A final root or Bray-Curtis divide may follow.
// The result is shown for one cycle with rsp_valid; the receiver cannot
// stall. Busy is already low in the strobe cycle, so the next transaction
// can be taken at the edge that ends it.
// Configuration writes on the csr_ port take effect at once; the user must
// make them while busy is low; the block does not enforce it. Reset sets
// metric 0 and 64 columns in use; matrix contents stay undefined until written.
`timescale 1ns / 1ps
module multi_metric_row_distance
   import mmrd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic [7:0]         req_row_a,
   input  logic [7:0]         req_row_b,
   input  logic [5:0]         req_column,
   input  logic signed [31:0] req_value,
   input  logic               req_value_missing,
   output logic               rsp_valid,
   output logic [47:0]        rsp_distance,
   output logic               rsp_no_data,
   output logic               rsp_bad_value,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [6:0]         csr_write_data
);
   state_type state_ff, state_in;
   logic [3:0]  metric_ff;
   logic [6:0]  cols_ff;
   logic [7:0]  ra_ff, ra_in, rb_ff, rb_in;
   logic [6:0]  col_ff, col_in, ncol;
   logic [6:0]  count_ff, count_in;
   logic        bad_ff, bad_in, ovf_ff, ovf_in;
   logic [63:0] usum_ff, usum_in;
   logic signed [39:0] tot_ff, tot_in;
   logic signed [63:0] ssum_ff, ssum_in;
   logic [32:0] a_ff, a_in;
   logic signed [31:0] av_ff, av_in, bv_ff, bv_in;
   logic signed [32:0] den_ff, den_in;
   logic [31:0] mop_ff, mop_in;
   logic [63:0] prod_ff;
   logic [23:0] qa_ff, qa_in;
   logic        rsp_valid_ff, rsp_valid_in, rsp_nd_ff, rsp_nd_in, rsp_bad_ff, rsp_bad_in;
   logic [47:0] rsp_dist_ff, rsp_dist_in;

   logic                  ram_we;
   logic [ADDR_BITS-1:0]  ram_raddr;
   logic [ENTRY_BITS-1:0] ram_rdata;
   logic        sq_start, sq_done;
   logic [63:0] sq_rad;
   logic [5:0]  sq_steps;
   logic [39:0] sq_root;
   logic        dv_start, dv_done;
   logic [63:0] dv_dividend, dv_quot;
   logic [39:0] dv_divisor, dv_rem;

   logic signed [31:0] bv;
   logic signed [32:0] diff, sum_ab;
   logic [32:0] ad33;
   logic [31:0] ad;
   logic [64:0] usum_add;
   logic [23:0] dd;
   logic [32:0] mden;
   logic [64:0] qfull;
   logic signed [63:0] ssum_add;
   logic [48:0] rnd;

   mmrd_matrix_ram u_ram (
      .clock(clock), .write_enable(ram_we),
      .write_addr({req_row_a, req_column}),
      .write_data({req_value_missing, req_value}),
      .read_addr(ram_raddr), .read_data(ram_rdata)
   );

   mmrd_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(sq_rad),
      .steps(sq_steps), .done(sq_done), .root(sq_root)
   );

   mmrd_div u_div (
      .clock(clock), .reset(reset), .start(dv_start), .dividend(dv_dividend),
      .divisor(dv_divisor), .done(dv_done), .quotient(dv_quot), .remainder(dv_rem)
   );

   assign ncol = (cols_ff > MAX_COLS) ? MAX_COLS : cols_ff;
   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      ra_in = ra_ff;
      rb_in = rb_ff;
      col_in = col_ff;
      count_in = count_ff;
      bad_in = bad_ff;
      ovf_in = ovf_ff;
      usum_in = usum_ff;
      tot_in = tot_ff;
      ssum_in = ssum_ff;
      a_in = a_ff;
      av_in = av_ff;
      bv_in = bv_ff;
      den_in = den_ff;
      mop_in = mop_ff;
      qa_in = qa_ff;
      rsp_valid_in = 1'b0;
      rsp_nd_in = 1'b0;
      rsp_bad_in = 1'b0;
      rsp_dist_in = '0;
      ram_we = 1'b0;
      ram_raddr = {ra_ff, col_ff[COL_BITS-1:0]};
      sq_start = 1'b0;
      sq_rad = '0;
      sq_steps = SQ_STEPS_INT;
      dv_start = 1'b0;
      dv_dividend = prod_ff;
      dv_divisor = {7'd0, mden};

      bv = $signed(ram_rdata[31:0]);
      diff = {av_ff[31], av_ff} - {bv[31], bv};
      sum_ab = {av_ff[31], av_ff} + {bv[31], bv};
      ad33 = diff[32] ? -diff : diff;
      ad = ad33[31:0];
      usum_add = {1'b0, usum_ff} + {1'b0, prod_ff};
      dd = (qa_ff > sq_root[23:0]) ? qa_ff - sq_root[23:0] : sq_root[23:0] - qa_ff;
      mden = den_ff[32] ? -den_ff : den_ff;
      qfull = {1'b0, dv_quot} + {64'd0, ({dv_rem[32:0], 1'b0} >= {1'b0, mden})};
      ssum_add = den_ff[32] ? ssum_ff - $signed(qfull[63:0]) : ssum_ff + $signed(qfull[63:0]);
      rnd = {1'b0, usum_ff[63:16]} + {48'd0, usum_ff[15]};

      case (state_ff)
         S_IDLE: begin
            if (start && (req_operation == OP_LOAD)) begin
               ram_we = 1'b1;
            end else if (start) begin
               ra_in = req_row_a;
               rb_in = req_row_b;
               col_in = '0;
               count_in = '0;
               bad_in = 1'b0;
               ovf_in = 1'b0;
               usum_in = '0;
               tot_in = '0;
               ssum_in = '0;
               if (metric_ff > MET_ALT_GOWER) begin
                  rsp_valid_in = 1'b1;
                  rsp_bad_in = 1'b1;
               end else begin
                  state_in = S_RDA;
               end
            end
         end
         S_RDA: begin
            if (col_ff == ncol) begin
               state_in = S_FIN;
            end else begin
               state_in = S_RDB;
            end
         end
         S_RDB: begin
            ram_raddr = {rb_ff, col_ff[COL_BITS-1:0]};
            a_in = ram_rdata;
            av_in = $signed(ram_rdata[31:0]);
            state_in = S_COL;
         end
         S_COL: begin
            // The row B entry arrives here; row A was captured in S_RDB, the state before.
            bv_in = bv;
            den_in = sum_ab;
            mop_in = ad;
            col_in = col_ff + 7'd1;
            state_in = S_RDA;
            if (!(a_ff[32] || ram_rdata[32])) begin
               case (metric_ff) inside
                  MET_EUCLID, MET_SQ_EUCLID: begin
                     count_in = count_ff + 7'd1;
                     col_in = col_ff;
                     state_in = S_MUL;
                  end
                  MET_CHORD, MET_SQ_CHORD: begin
                     count_in = count_ff + 7'd1;
                     if (av_ff[31] || bv[31]) begin
                        bad_in = 1'b1;
                     end else begin
                        sq_start = 1'b1;
                        sq_rad = {32'd0, av_ff};
                        sq_steps = SQ_STEPS_FRAC;
                        col_in = col_ff;
                        state_in = S_SQA;
                     end
                  end
                  MET_CHISQ, MET_SQ_CHISQ: begin
                     if (av_ff != 0 || bv != 0) begin
                        count_in = count_ff + 7'd1;
                        if (sum_ab == 0) begin
                           bad_in = 1'b1;
                        end else begin
                           col_in = col_ff;
                           state_in = S_MUL;
                        end
                     end
                  end
                  default: begin
                     count_in = count_ff + 7'd1;
                     usum_in = usum_ff + {32'd0, ad};
                     tot_in = tot_ff + {{7{sum_ab[32]}}, sum_ab};
                  end
               endcase
            end
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            if ((metric_ff == MET_CHISQ) || (metric_ff == MET_SQ_CHISQ)) begin
               dv_start = 1'b1;
               state_in = S_DIV;
            end else begin
               if (usum_add[64]) begin
                  ovf_in = 1'b1;
                  usum_in = '1;
               end else begin
                  usum_in = usum_add[63:0];
               end
               col_in = col_ff + 7'd1;
               state_in = S_RDA;
            end
         end
         S_SQA: begin
            if (sq_done) begin
               qa_in = sq_root[23:0];
               sq_start = 1'b1;
               sq_rad = {32'd0, bv_ff};
               sq_steps = SQ_STEPS_FRAC;
               state_in = S_SQB;
            end
         end
         S_SQB: begin
            if (sq_done) begin
               mop_in = {8'd0, dd};
               state_in = S_MUL;
            end
         end
         S_DIV: begin
            if (dv_done) begin
               state_in = S_CHI;
            end
         end
         S_CHI: begin
            if (qfull > {1'b0, CHI_LIM}) begin
               ovf_in = 1'b1;
            end else if (ssum_add > CHI_LIM) begin
               ovf_in = 1'b1;
               ssum_in = CHI_LIM;
            end else if (ssum_add < -CHI_LIM) begin
               ovf_in = 1'b1;
               ssum_in = -CHI_LIM;
            end else begin
               ssum_in = ssum_add;
            end
            col_in = col_ff + 7'd1;
            state_in = S_RDA;
         end
         S_FIN: begin
            state_in = S_IDLE;
            if (count_ff == 0) begin
               rsp_valid_in = 1'b1;
               rsp_nd_in = 1'b1;
            end else if (bad_ff) begin
               rsp_valid_in = 1'b1;
               rsp_bad_in = 1'b1;
            end else if (ovf_ff) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in = DIST_MAX;
            end else begin
               case (metric_ff) inside
                  MET_EUCLID, MET_CHORD: begin
                     sq_start = 1'b1;
                     sq_rad = usum_ff;
                     sq_steps = SQ_STEPS_INT;
                     state_in = S_FROOT;
                  end
                  MET_SQ_EUCLID, MET_SQ_CHORD: begin
                     rsp_valid_in = 1'b1;
                     rsp_dist_in = rnd[48] ? DIST_MAX : rnd[47:0];
                  end
                  MET_BRAY: begin
                     if (tot_ff == 0) begin
                        rsp_valid_in = 1'b1;
                        rsp_bad_in = 1'b1;
                     end else if (tot_ff < 0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        dv_start = 1'b1;
                        dv_dividend = {usum_ff[47:0], 16'd0} + {25'd0, tot_ff[39:1]};
                        dv_divisor = tot_ff[39:0];
                        state_in = S_FDIV;
                     end
                  end
                  MET_CHISQ: begin
                     if (ssum_ff < 0) begin
                        rsp_valid_in = 1'b1;
                        rsp_bad_in = 1'b1;
                     end else begin
                        sq_start = 1'b1;
                        sq_rad = ssum_ff;
                        sq_steps = SQ_STEPS_FRAC;
                        state_in = S_FROOT;
                     end
                  end
                  MET_SQ_CHISQ: begin
                     rsp_valid_in = 1'b1;
                     if (ssum_ff >= 0) begin
                        rsp_dist_in = (ssum_ff[63:48] != 0) ? DIST_MAX : ssum_ff[47:0];
                     end
                  end
                  MET_ALT_GOWER: begin
                     sq_start = 1'b1;
                     sq_rad = {usum_ff[62:0], 1'b0};
                     sq_steps = SQ_STEPS_FRAC;
                     state_in = S_FROOT;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_dist_in = (usum_ff[63:48] != 0) ? DIST_MAX : usum_ff[47:0];
                  end
               endcase
            end
         end
         S_FROOT: begin
            if (sq_done) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in = {8'd0, sq_root};
               state_in = S_IDLE;
            end
         end
         S_FDIV: begin
            if (dv_done) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in = (dv_quot[63:48] != 0) ? DIST_MAX : dv_quot[47:0];
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         metric_ff <= MET_EUCLID;
         cols_ff <= MAX_COLS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable && (csr_index == CSR_METRIC)) begin
            metric_ff <= csr_write_data[3:0];
         end
         if (csr_write_enable && (csr_index == CSR_COLS)) begin
            cols_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      ra_ff <= ra_in;
      rb_ff <= rb_in;
      col_ff <= col_in;
      count_ff <= count_in;
      bad_ff <= bad_in;
      ovf_ff <= ovf_in;
      usum_ff <= usum_in;
      tot_ff <= tot_in;
      ssum_ff <= ssum_in;
      a_ff <= a_in;
      av_ff <= av_in;
      bv_ff <= bv_in;
      den_ff <= den_in;
      mop_ff <= mop_in;
      qa_ff <= qa_in;
      prod_ff <= mop_ff * mop_ff;
      rsp_nd_ff <= rsp_nd_in;
      rsp_bad_ff <= rsp_bad_in;
      rsp_dist_ff <= rsp_dist_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_no_data = rsp_nd_ff;
   assign rsp_bad_value = rsp_bad_ff;
endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the row-pair distance engine: random loads, compares and metrics.
`timescale 1ns / 1ps
module testbench;
   import mmrd_pkg::*;

   typedef struct packed {
      logic [47:0] distance;
      logic        no_data;
      logic        bad_value;
   } dist_result_type;

   class distance_scoreboard;
      localparam longint CHI_CAP = 64'sh2000_0000_0000_0000;
      logic [31:0]  cell_value [16384];
      bit           cell_missing [16384];
      bit [3:0]     cur_metric;
      bit [6:0]     cur_cols;
      dist_result_type pending_q [$];
      int           fail_count;

      function new();
         cur_metric = MET_EUCLID;
         cur_cols = 7'd64;
         fail_count = 0;
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         fail_count++;
      endtask

      function void set_reg(bit idx, bit [6:0] data);
         if (idx == CSR_METRIC) cur_metric = data[3:0];
         else cur_cols = data;
      endfunction

      // Digit-by-digit floor root of s scaled by 4 to the power extra.
      function longint unsigned floor_root(longint unsigned s, int extra);
         longint unsigned r, rem, trial, pr;
         r = 0;
         rem = 0;
         for (int i = 31 + extra; i >= 0; i--) begin
            pr = (i >= extra) ? ((s >> (2 * (i - extra))) & 64'd3) : 64'd0;
            rem = (rem << 2) | pr;
            trial = (r << 2) | 64'd1;
            if (rem >= trial) begin
               rem -= trial;
               r = (r << 1) | 64'd1;
            end else begin
               r = r << 1;
            end
         end
         return r;
      endfunction

      function bit read_cell(bit [7:0] row, int col, output longint v);
         int k;
         k = row * 64 + col;
         v = longint'($signed(cell_value[k]));
         return !cell_missing[k];
      endfunction

      function void note(bit op, bit [7:0] ra, bit [7:0] rb, bit [5:0] col,
                         logic [31:0] val, bit miss);
         longint a, b, d, tot, ssum, den;
         longint unsigned ad, sq, usum, res, qa, qb, dd, m, q;
         int ncol, cnt;
         bit bad, ovf;
         dist_result_type r;
         if (op == OP_LOAD) begin
            cell_value[{ra, col}] = val;
            cell_missing[{ra, col}] = miss;
            return;
         end
         r = '0;
         if (cur_metric > MET_ALT_GOWER) begin
            r.bad_value = 1;
            pending_q.push_back(r);
            return;
         end
         ncol = (cur_cols > 64) ? 64 : cur_cols;
         tot = 0; ssum = 0; usum = 0; res = 0; cnt = 0; bad = 0; ovf = 0;
         for (int j = 0; j < ncol; j++) begin
            if (!read_cell(ra, j, a) || !read_cell(rb, j, b)) continue;
            d = a - b;
            ad = (d < 0) ? -d : d;
            case (cur_metric)
               MET_EUCLID, MET_SQ_EUCLID: begin
                  cnt++;
                  if (ad >= 64'h1_0000_0000) ovf = 1;
                  else begin
                     sq = ad * ad;
                     if (usum > ~64'd0 - sq) begin
                        ovf = 1;
                        usum = ~64'd0;
                     end else usum += sq;
                  end
               end
               MET_CHORD, MET_SQ_CHORD: begin
                  cnt++;
                  if (a < 0 || b < 0) bad = 1;
                  else begin
                     qa = floor_root(a, 8);
                     qb = floor_root(b, 8);
                     dd = (qa > qb) ? qa - qb : qb - qa;
                     usum += dd * dd;
                  end
               end
               MET_BRAY: begin
                  cnt++;
                  usum += ad;
                  tot += a + b;
               end
               MET_CHISQ, MET_SQ_CHISQ: begin
                  // A column where both values are zero does not count at all.
                  if (!(a == 0 && b == 0)) begin
                     cnt++;
                     den = a + b;
                     if (den == 0) bad = 1;
                     else if (ad >= 64'h1_0000_0000) ovf = 1;
                     else begin
                        sq = ad * ad;
                        m = (den < 0) ? -den : den;
                        q = sq / m;
                        if ((sq % m) * 2 >= m) q++;
                        if (q > 64'h2000_0000_0000_0000) ovf = 1;
                        else begin
                           ssum += (den < 0) ? -longint'(q) : longint'(q);
                           if (ssum > CHI_CAP) begin ovf = 1; ssum = CHI_CAP; end
                           if (ssum < -CHI_CAP) begin ovf = 1; ssum = -CHI_CAP; end
                        end
                     end
                  end
               end
               default: begin
                  cnt++;
                  usum += ad;
               end
            endcase
         end
         if (cnt == 0) r.no_data = 1;
         else if (bad) r.bad_value = 1;
         else if (ovf) r.distance = DIST_MAX;
         else begin
            case (cur_metric)
               MET_EUCLID, MET_CHORD: res = floor_root(usum, 0);
               MET_SQ_EUCLID, MET_SQ_CHORD: res = (usum >> 16) + ((usum >> 15) & 64'd1);
               MET_BRAY: begin
                  if (tot == 0) r.bad_value = 1;
                  else if (tot < 0) res = 0;
                  else res = ((usum << 16) + longint'(tot) / 2) / longint'(tot);
               end
               MET_CHISQ: begin
                  if (ssum < 0) r.bad_value = 1;
                  else res = floor_root(ssum, 8);
               end
               MET_SQ_CHISQ: res = (ssum < 0) ? 0 : ssum;
               MET_ALT_GOWER: res = floor_root(2 * usum, 8);
               default: res = usum;
            endcase
            if (!r.bad_value) r.distance = (res > DIST_MAX) ? DIST_MAX : res[47:0];
         end
         pending_q.push_back(r);
      endfunction

      task check(dist_result_type got);
         dist_result_type want;
         if (pending_q.size() == 0) begin
            report("result with no compare outstanding");
            return;
         end
         want = pending_q.pop_front();
         if (got.distance !== want.distance)
            report($sformatf("distance %h, expected %h", got.distance, want.distance));
         if (got.no_data !== want.no_data)
            report($sformatf("no_data %b, expected %b", got.no_data, want.no_data));
         if (got.bad_value !== want.bad_value)
            report($sformatf("bad_value %b, expected %b", got.bad_value, want.bad_value));
      endtask

      function int pending();
         return pending_q.size();
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic               req_operation = 0;
   logic [7:0]         req_row_a = 0;
   logic [7:0]         req_row_b = 0;
   logic [5:0]         req_column = 0;
   logic signed [31:0] req_value = 0;
   logic               req_value_missing = 0;
   logic               rsp_valid;
   logic [47:0]        rsp_distance;
   logic               rsp_no_data;
   logic               rsp_bad_value;
   logic               csr_write_enable = 0;
   logic               csr_index = 0;
   logic [6:0]         csr_write_data = 0;

   distance_scoreboard sb = new();
   bit [7:0] pool_rows [8] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd252, 8'd253, 8'd254, 8'd255};
   bit quiet = 0;

   multi_metric_row_distance u_top (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock)
      if (!reset && rsp_valid) sb.check({rsp_distance, rsp_no_data, rsp_bad_value});

   initial begin
      #300ms;
      $display("FAILURE");
      $finish;
   end

   task send(bit op, bit [7:0] ra, bit [7:0] rb, bit [5:0] col, logic [31:0] val, bit miss);
      @(negedge clock);
      start = 1;
      req_operation = op;
      req_row_a = ra;
      req_row_b = rb;
      req_column = col;
      req_value = val;
      req_value_missing = miss;
      do @(posedge clock); while (busy);
      sb.note(op, ra, rb, col, val, miss);
   endtask

   task idle_burst();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         start = 0;
         repeat ($urandom_range(0, 11)) @(negedge clock);
      end
   endtask

   // Lets every compare finish before a register changes.
   task drain();
      @(negedge clock);
      start = 0;
      while (sb.pending() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_reg(bit idx, bit [6:0] data);
      @(negedge clock);
      csr_write_enable = 1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 0;
      sb.set_reg(idx, data);
   endtask

   function logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h0;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3, 4, 5: return $urandom_range(0, 32'h0004_0000);
         6: return -$urandom_range(0, 32'h0004_0000);
         7, 8: return $urandom;
         default: return $urandom & 32'h00FF_FFFF;
      endcase
   endfunction

   initial begin
      int n_items;
      bit [6:0] cols;
      bit [3:0] met;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Every row that is ever compared gets all of its columns written first.
      foreach (pool_rows[i])
         for (int c = 0; c < 64; c++)
            send(OP_LOAD, pool_rows[i], 8'($urandom), c[5:0], pick_value(),
                 $urandom_range(0, 7) == 0);

      // Extreme values in two columns, tried under every metric code.
      send(OP_LOAD, 8'd0, 8'd0, 6'd0, 32'h7FFF_FFFF, 0);
      send(OP_LOAD, 8'd255, 8'd0, 6'd0, 32'h8000_0000, 0);
      send(OP_LOAD, 8'd0, 8'd0, 6'd1, 32'h0, 0);
      send(OP_LOAD, 8'd255, 8'd0, 6'd1, 32'h0, 0);
      drain();
      write_reg(CSR_COLS, 7'd2);
      for (int m = 0; m < 16; m++) begin
         drain();
         write_reg(CSR_METRIC, m[6:0]);
         send(OP_COMPARE, 8'd0, 8'd255, 6'd0, 32'h0, 0);
      end
      drain();
      write_reg(CSR_COLS, 7'd0);
      send(OP_COMPARE, 8'd0, 8'd255, 6'd0, 32'h0, 0);

      for (int ph = 0; ph < 18; ph++) begin
         quiet = (ph >= 15);
         met = (ph < 10) ? ph[3:0] : 4'($urandom_range(0, 15));
         case (ph)
            3, 12: cols = 7'd64;
            8: cols = 7'd127;
            11: cols = 7'd0;
            14: cols = 7'd1;
            default: cols = 7'($urandom_range(1, 8));
         endcase
         n_items = (cols > 8) ? 14 : 36;
         drain();
         write_reg(CSR_METRIC, {3'd0, met});
         write_reg(CSR_COLS, cols);
         for (int i = 0; i < n_items; i++) begin
            int sel;
            sel = $urandom_range(0, 9);
            idle_burst();
            if (sel < 5)
               send(OP_COMPARE, pool_rows[$urandom_range(0, 7)],
                    pool_rows[$urandom_range(0, 7)], 6'($urandom), $urandom, 1'($urandom));
            else if (sel < 9)
               send(OP_LOAD, pool_rows[$urandom_range(0, 7)], 8'($urandom),
                    (cols > 0 && cols < 64) ? 6'($urandom_range(0, cols - 1))
                                            : 6'($urandom_range(0, 63)),
                    pick_value(), $urandom_range(0, 6) == 0);
            else
               send(OP_LOAD, 8'($urandom), 8'($urandom), 6'($urandom), $urandom,
                    1'($urandom));
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (sb.pending() != 0) sb.report("compares left without a result");
      if (sb.fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/mmrd_pkg.sv
rtl/mmrd_matrix_ram.sv
rtl/mmrd_sqrt.sv
rtl/mmrd_div.sv
rtl/multi_metric_row_distance.sv
bench/testbench.sv
